// File: sv/rgpg_pkg.sv
// Shared constants for the radial gradient pixel generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package rgpg_pkg;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_DIM_W  = 13;
  localparam int DENS_W     = 17;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DENSITY = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_COLOR   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_COLOR   = 3'd4;

  localparam logic [CFG_DIM_W-1:0] RST_WIDTH   = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT  = 13'd480;
  localparam logic [DENS_W-1:0]    RST_DENSITY = 17'd0;
  localparam logic [COLOR_W-1:0]   RST_INNER   = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0]   RST_OUTER   = 32'hFF00_0000;

  localparam logic [DENS_W-1:0]    DENSITY_ONE = 17'h1_0000;
  localparam int DENS_FRAC = 16;
  localparam int DIST_FRAC_SHIFT = 14;
endpackage
`default_nettype wire

// File: sv/rgpg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Uses rgpg_pkg only for house consistency; no submodules.
`default_nettype none
module rgpg_sqrt
  import rgpg_pkg::*;
#(
  parameter int IN_W  = 41,
  parameter int OUT_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [IN_W-1:0]  in_val,
  output logic                  out_vld,
  output logic [OUT_W-1:0]      out_root
);
  logic [IN_W-1:0] v_r   [OUT_W+1];
  logic [IN_W-1:0] res_r [OUT_W+1];
  logic            vld_r [OUT_W+1];

  assign v_r[0]   = in_val;
  assign res_r[0] = '0;
  assign vld_r[0] = in_vld;

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int SH = 2 * (OUT_W - 1 - k);
    logic [IN_W-1:0] bit_v, trial;
    logic            take;
    assign bit_v = IN_W'(1) << SH;
    assign trial = res_r[k] + bit_v;
    assign take  = v_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        v_r[k+1]   <= take ? v_r[k] - trial : v_r[k];
        res_r[k+1] <= take ? (res_r[k] >> 1) + bit_v : res_r[k] >> 1;
      end
    end
  end

  assign out_vld  = vld_r[OUT_W];
  assign out_root = res_r[OUT_W][OUT_W-1:0];
endmodule
`default_nettype wire

// File: sv/rgpg_div.sv
// Pipelined restoring divider for the blend factor, one quotient bit per stage.
// Produces the Q1.F factor including the zero and full-scale clamps.
`default_nettype none
module rgpg_div
  import rgpg_pkg::*;
#(
  parameter int DEN_W = 37,
  parameter int FB    = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [DEN_W-1:0] in_num,
  input  wire logic            in_zero,
  input  wire logic            in_one,
  input  wire logic [DEN_W-1:0] den,
  output logic                 out_vld,
  output logic [FB:0]          out_factor
);
  logic [DEN_W-1:0] rem_r  [FB+1];
  logic [FB-1:0]    q_r    [FB+1];
  logic             zero_r [FB+1];
  logic             one_r  [FB+1];
  logic             vld_r  [FB+1];

  assign rem_r[0]  = in_num;
  assign q_r[0]    = '0;
  assign zero_r[0] = in_zero;
  assign one_r[0]  = in_one;
  assign vld_r[0]  = in_vld;

  for (genvar k = 0; k < FB; k++) begin : g_stage
    logic [DEN_W:0] t;
    logic           take;
    assign t    = {rem_r[k], 1'b0};
    assign take = t >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        rem_r[k+1]  <= take ? DEN_W'(t - {1'b0, den}) : DEN_W'(t);
        q_r[k+1]    <= {q_r[k][FB-2:0], take};
        zero_r[k+1] <= zero_r[k];
        one_r[k+1]  <= one_r[k];
      end
    end
  end

  assign out_vld    = vld_r[FB];
  assign out_factor = zero_r[FB] ? '0 :
                      one_r[FB]  ? (FB+1)'(1) << FB : {1'b0, q_r[FB]};
endmodule
`default_nettype wire

// File: sv/rgpg_blend.sv
// Output stage: mixes inner and outer colors per channel by the factor.
// Holds the result register that faces the receiver.
`default_nettype none
module rgpg_blend
  import rgpg_pkg::*;
#(
  parameter int FB = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic [FB:0]        factor,
  input  wire logic [COLOR_W-1:0] inner,
  input  wire logic [COLOR_W-1:0] outer,
  output logic                    out_vld,
  output logic [COLOR_W-1:0]      out_rgba
);
  logic [COLOR_W-1:0] rgba_nxt, rgba_r;
  logic               vld_r;
  logic [FB:0]        inv_f;

  assign inv_f = ((FB+1)'(1) << FB) - factor;

  always_comb begin
    logic [FB+9:0] sum;
    logic [FB+9:0] mix;
    rgba_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      sum = (FB+10)'(outer[8*c +: 8]) * (FB+10)'(factor)
          + (FB+10)'(inner[8*c +: 8]) * (FB+10)'(inv_f);
      mix = sum >> FB;
      rgba_nxt[8*c +: 8] = (mix > (FB+10)'(255)) ? 8'hFF : mix[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rgba_r <= rgba_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_rgba = rgba_r;
endmodule
`default_nettype wire

// File: sv/radial_gradient_pixel_generator.sv
// Radial gradient pixel generator.
// Input stream: one pixel coordinate per transfer, in_tdata = {pixel_y, pixel_x}.
// Output stream: one RGBA word per input, in the same order.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr
// (width, height, density, inner color, outer color); write only while idle.
// Pipeline: stage A, stage B, the bit-per-stage square root (21 stages),
// stage C, the divider (16 stages) and the blend register; every stage is
// a register with a valid bit. Throughput: one pixel per clock unless stalled.
// Stall: when out_tvalid is high and out_tready low the whole pipeline holds,
// in_tready drops, and nothing is lost or repeated.
// Reset (rst_n low, synchronous): valid bits clear, registers take their
// defaults 640, 480, 0, 0xFFFFFFFF, 0xFF000000.
// Dimension and density writes reach the datapath via derived-geometry registers.
// Depends on rgpg_pkg, rgpg_sqrt, rgpg_div, rgpg_blend.
`default_nettype none
module radial_gradient_pixel_generator
  import rgpg_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,    // pixel_x [11:0], pixel_y [23:12]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,   // pixel_rgba [31:0]
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);
  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int AW     = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int SQ_W   = 2 * AW + 1;
  localparam int SQS_W  = SQ_W + DIST_FRAC_SHIFT;
  localparam int ROOT_W = (SQS_W + 1) / 2;
  localparam int RAD_W  = DIM_W + 7;
  localparam int DEN_W  = RAD_W + DENS_W;
  localparam int LHS_W  = ROOT_W + DENS_FRAC;
  localparam int CW     = ((LHS_W > DEN_W) ? LHS_W : DEN_W) + 1;

  logic en;

  // configuration registers
  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [DENS_W-1:0]    dens_r;
  logic [COLOR_W-1:0]   inner_r, outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      dens_r   <= RST_DENSITY;
      inner_r  <= RST_INNER;
      outer_r  <= RST_OUTER;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:   width_r  <= cfg_wr_data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_r <= cfg_wr_data[CFG_DIM_W-1:0];
        REG_INNER_DENSITY: dens_r   <= cfg_wr_data[DENS_W-1:0];
        REG_INNER_COLOR:   inner_r  <= cfg_wr_data;
        REG_OUTER_COLOR:   outer_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // derived geometry, recomputed every cycle from the registers
  logic [DIM_W-1:0]  w_r, h_r;
  logic [DENS_W-1:0] dc_r;
  logic [RAD_W-1:0]  rad_r;
  logic [DEN_W-1:0]  sub_r, den_r;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    logic [AW-1:0] dx;
    dx = AW'(d);
    if (d == '0) return DIM_W'(1);
    if (dx > AW'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
    return DIM_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    w_r   <= clamp_dim(width_r);
    h_r   <= clamp_dim(height_r);
    dc_r  <= (dens_r > DENSITY_ONE) ? DENSITY_ONE : dens_r;
    rad_r <= RAD_W'((w_r < h_r) ? w_r : h_r) << 7;
    sub_r <= DEN_W'(rad_r) * DEN_W'(dc_r);
    den_r <= DEN_W'(rad_r) * DEN_W'(DENSITY_ONE - dc_r);
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage A: half-pixel offsets from the center
  logic [AW-1:0] adx_r, ady_r;
  logic          a_vld_r;
  logic signed [AW+1:0] dx, dy;
  assign dx = $signed({2'b00, AW'(in_tdata[COORD_W-1:0]) << 1}) -
              $signed((AW+2)'(w_r));
  assign dy = $signed({2'b00, AW'(in_tdata[2*COORD_W-1:COORD_W]) << 1}) -
              $signed((AW+2)'(h_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
    if (en) begin
      adx_r <= AW'(dx[AW+1] ? -dx : dx);
      ady_r <= AW'(dy[AW+1] ? -dy : dy);
    end
  end

  // stage B: squared distance in 2^-16 pixel^2 units
  logic [SQS_W-1:0] sq_r;
  logic             b_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
    if (en) begin
      sq_r <= SQS_W'(SQ_W'(adx_r) * SQ_W'(adx_r) + SQ_W'(ady_r) * SQ_W'(ady_r))
              << DIST_FRAC_SHIFT;
    end
  end

  logic              s_vld;
  logic [ROOT_W-1:0] dist_root;
  rgpg_sqrt #(.IN_W(SQS_W), .OUT_W(ROOT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(b_vld_r), .in_val(sq_r),
    .out_vld(s_vld), .out_root(dist_root)
  );

  // stage C: numerator and clamp decisions
  logic [CW-1:0]    lhs, num;
  logic [DEN_W-1:0] num_r;
  logic             zero_r, one_r, c_vld_r;
  assign lhs = CW'({dist_root, DENS_FRAC'(0)});
  assign num = lhs - CW'(sub_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= s_vld;
    end
    if (en) begin
      zero_r <= lhs <= CW'(sub_r);
      one_r  <= num >= CW'(den_r);
      num_r  <= num[DEN_W-1:0];
    end
  end

  logic                   d_vld;
  logic [FRACTION_BITS:0] factor;
  rgpg_div #(.DEN_W(DEN_W), .FB(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(c_vld_r), .in_num(num_r), .in_zero(zero_r), .in_one(one_r),
    .den(den_r), .out_vld(d_vld), .out_factor(factor)
  );

  rgpg_blend #(.FB(FRACTION_BITS)) u_blend (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(d_vld), .factor(factor), .inner(inner_r), .outer(outer_r),
    .out_vld(out_tvalid), .out_rgba(out_tdata)
  );
endmodule
`default_nettype wire

// File: sv/rgpg_checker.sv
// Port-level checks for the radial gradient pixel generator.
// Bound to the top level; depends on rgpg_pkg.
`default_nettype none
module rgpg_checker
  import rgpg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transfer changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind radial_gradient_pixel_generator rgpg_checker u_rgpg_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
